FILE: hdl/lcht_pkg.sv
package lcht_pkg;

   // Cache geometry
   localparam int MAX_ENTRIES = 512;
   localparam int ID_WIDTH    = 10;

   // Port field widths are fixed by the interface
   localparam int FIELD_WIDTH = 10;
   localparam int CAP_WIDTH   = 10;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(10);

   // Fill count must hold MAX_ENTRIES itself
   localparam int FILL_WIDTH  = $clog2(MAX_ENTRIES + 1);
   localparam int INDEX_WIDTH = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef logic [ID_WIDTH-1:0]    id_type;
   typedef logic [FILL_WIDTH-1:0]  fill_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   // Wave token passed from cell to cell
   typedef struct packed {
      logic   valid;   // token present at this link
      logic   active;  // still looking for its stop point
      logic   hit;     // key was found in some cell
      logic   evict;   // carry is the identifier pushed out of the cache
      id_type carry;   // identifier displaced from the cell above
   } link_type;

   // Per-request values broadcast to every cell
   typedef struct packed {
      id_type   key;
      fill_type fill;
      logic     full;
   } chain_ctrl_type;

endpackage

FILE: hdl/lcht_cell.sv
module lcht_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lcht_pkg::index_type     slot_index,
   input  lcht_pkg::chain_ctrl_type ctrl,
   input  lcht_pkg::link_type      link_i,
   output lcht_pkg::link_type      link_o
);
   import lcht_pkg::*;

   id_type   id_ff;
   id_type   id_in;
   link_type link_ff;
   link_type link_in;
   logic     slot_used;

   // Slots below the fill count hold live entries
   assign slot_used = FILL_WIDTH'(slot_index) < ctrl.fill;

   // Swap the carried identifier in, or stop the token here
   always_comb begin
      id_in   = id_ff;
      link_in = '0;
      if (link_i.valid) begin
         link_in = link_i;
         if (link_i.active) begin
            if (slot_used) begin
               id_in = link_i.carry;
               if (id_ff == ctrl.key) begin
                  link_in.active = 1'b0;
                  link_in.hit    = 1'b1;
               end else begin
                  link_in.carry = id_ff;
               end
            end else begin
               // first free slot: insert, or report the LRU entry when full
               link_in.active = 1'b0;
               if (ctrl.full) begin
                  link_in.evict = 1'b1;
               end else begin
                  id_in = link_i.carry;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   assign link_o = link_ff;

endmodule

FILE: hdl/lcht_chain.sv
module lcht_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  lcht_pkg::chain_ctrl_type ctrl,
   input  lcht_pkg::link_type       link_i,
   output lcht_pkg::link_type       link_o
);
   import lcht_pkg::*;

   link_type links [MAX_ENTRIES+1];

   assign links[0] = link_i;

   // Row of slots, most recently used first
   for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      lcht_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_index (INDEX_WIDTH'(gi)),
         .ctrl       (ctrl),
         .link_i     (links[gi]),
         .link_o     (links[gi+1])
      );
   end

   assign link_o = links[MAX_ENTRIES];

endmodule

FILE: hdl/lru_cache_hit_tracker.sv
// Fully associative LRU cache of content identifiers.
//
// req_ channel: one content_id per transfer, taken when req_valid is high
// and req_stall is low. rsp_ channel: one result per request (hit,
// evicted, evicted_id, occupancy), taken when rsp_valid is high and
// rsp_stall is low. csr_wr_en writes csr_wr_data into the capacity
// register; write it only while no request is in flight.
//
// A request launches a token down a row of MAX_ENTRIES slot cells, one cell
// per cycle; each cell swaps its entry with the carried one until the key
// or the first free slot is met. The result is ready once the token leaves
// the last cell, and one request is worked on at a time, so a new request
// is not taken until the result of the last one has been taken.
//
// Reset empties the cache (fill count zero), sets capacity to 10 and
// clears any request in flight. While rsp_stall holds the result, the
// result stays put and no new request is taken.
module lru_cache_hit_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lcht_pkg::FIELD_WIDTH-1:0]    req_content_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [lcht_pkg::FIELD_WIDTH-1:0]    rsp_evicted_id,
   output logic [lcht_pkg::FIELD_WIDTH-1:0]    rsp_occupancy,
   input  logic                                csr_wr_en,
   input  logic [lcht_pkg::CAP_WIDTH-1:0]      csr_wr_data
);
   import lcht_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CAP_WIDTH-1:0] cap_ff;
   fill_type            fill_ff, fill_in;
   fill_type            cap_eff;
   id_type              key_ff;
   logic                full_ff;
   link_type            launch_ff, launch_in;
   link_type            end_link;
   chain_ctrl_type      ctrl;
   logic                req_take, rsp_take;
   logic                hit_ff, evict_ff;
   id_type              evict_id_ff;
   logic                end_evict;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Zero means one, anything beyond the row means the whole row
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = FILL_WIDTH'(1);
      end else if (32'(cap_ff) > MAX_ENTRIES) begin
         cap_eff = FILL_WIDTH'(MAX_ENTRIES);
      end else begin
         cap_eff = FILL_WIDTH'(cap_ff);
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff  <= ID_WIDTH'(req_content_id);
         full_ff <= (fill_ff >= cap_eff);
      end
   end

   // Token injected into the first cell
   always_comb begin
      launch_in = '0;
      if (req_take) begin
         launch_in.valid  = 1'b1;
         launch_in.active = 1'b1;
         launch_in.carry  = ID_WIDTH'(req_content_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= '0;
      end else begin
         launch_ff <= launch_in;
      end
   end

   assign ctrl.key  = key_ff;
   assign ctrl.fill = fill_ff;
   assign ctrl.full = full_ff;

   lcht_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .link_i (launch_ff),
      .link_o (end_link)
   );

   // A token still active past the last cell met a full row
   assign end_evict = end_link.evict || end_link.active;

   // Control and fill count
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (end_link.valid) begin
               state_in = ST_RESP;
               if (!end_link.hit && !end_evict) begin
                  fill_in = fill_ff + FILL_WIDTH'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_BUSY && end_link.valid) begin
         hit_ff      <= end_link.hit;
         evict_ff    <= end_evict;
         evict_id_ff <= end_evict ? end_link.carry : '0;
      end
   end

   assign rsp_hit        = hit_ff;
   assign rsp_evicted    = evict_ff;
   assign rsp_evicted_id = FIELD_WIDTH'(evict_id_ff);
   assign rsp_occupancy  = FIELD_WIDTH'(fill_ff);

   // Token leaves the row only while a request is in flight
   a_end_in_busy: assert property (@(posedge clock) disable iff (reset)
      end_link.valid |-> state_ff == ST_BUSY)
      else $error("token left the cell row outside a request");

   // A result never reports both a hit and an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction in one result");

   // Fill count grows by at most one and never beyond the row
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      fill_ff != $past(fill_ff) |-> fill_ff == $past(fill_ff) + FILL_WIDTH'(1))
      else $error("fill count jumped");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_ENTRIES)
      else $error("fill count beyond the row");

endmodule

FILE: tb/lru_cache_hit_tracker_test.sv
module lru_cache_hit_tracker_test;
   import lcht_pkg::*;

   localparam int WATCHDOG_LIMIT = 10000;
   localparam int MAX_GAP        = 10;
   localparam int LONG_HOLD      = 1500;
   localparam int LONG_HOLD_AT   = 800;
   localparam int TAIL_CYCLES    = 600;
   localparam int REPORT_LIMIT   = 10;

   typedef logic [FIELD_WIDTH-1:0] field_type;

   // One lookup outcome as it leaves the block
   typedef struct packed {
      logic      hit;
      logic      evicted;
      field_type evicted_id;
      field_type occupancy;
   } lookup_result_type;

   // Shadow LRU order plus the queue of outcomes still owed by the block
   class lru_shadow;
      id_type                order[MAX_ENTRIES];
      int                    fill;
      logic [CAP_WIDTH-1:0]  capacity;
      lookup_result_type     outstanding[$];
      int                    mismatches;

      function new();
         foreach (order[k]) order[k] = '0;
         fill       = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      // Apply one accepted request and queue the outcome it must produce
      function void note_request(id_type id);
         lookup_result_type want;
         int limit;
         int slot;
         int shift_from;
         int k;
         // zero means one entry, anything past the array saturates
         limit = (capacity == 0) ? 1 :
                 ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity));
         slot = -1;
         for (k = 0; k < fill; k++)
            if (slot < 0 && order[k] == id) slot = k;
         want = '0;
         if (slot >= 0) begin
            want.hit   = 1'b1;
            shift_from = slot;
         end else if (fill >= limit) begin
            want.evicted    = 1'b1;
            want.evicted_id = order[fill-1];
            shift_from      = fill - 1;
         end else begin
            shift_from = fill;
            fill++;
         end
         for (k = shift_from; k > 0; k--) order[k] = order[k-1];
         order[0] = id;
         want.occupancy = FIELD_WIDTH'(fill);
         outstanding.push_back(want);
      endfunction

      // Compare one result transfer with the oldest outcome owed
      function void check_result(lookup_result_type got);
         lookup_result_type want;
         if (outstanding.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: hit=%0d evicted=%0d evicted_id=%0d occupancy=%0d",
                        got.hit, got.evicted, got.evicted_id, got.occupancy);
            return;
         end
         want = outstanding.pop_front();
         if (got.hit !== want.hit || got.evicted !== want.evicted ||
             got.evicted_id !== want.evicted_id || got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result mismatch at %0t", $realtime);
               $display("  expected hit=%0d evicted=%0d evicted_id=%0d occupancy=%0d",
                        want.hit, want.evicted, want.evicted_id, want.occupancy);
               $display("  actual   hit=%0d evicted=%0d evicted_id=%0d occupancy=%0d",
                        got.hit, got.evicted, got.evicted_id, got.occupancy);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [FIELD_WIDTH-1:0] req_content_id;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic                  rsp_evicted;
   logic [FIELD_WIDTH-1:0] rsp_evicted_id;
   logic [FIELD_WIDTH-1:0] rsp_occupancy;
   logic                  csr_wr_en;
   logic [CAP_WIDTH-1:0]  csr_wr_data;

   lru_shadow board = new();
   bit        gaps_on = 1'b1;
   int        quiet_cycles = 0;

   // Directed opening: extremes, hits at both ends, fill to the reset capacity
   id_type directed_ids[$] = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'h155, 10'h2AA,
                               10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6,
                               10'd512, 10'd1023, 10'd0, 10'd0, 10'h3FF, 10'h200,
                               10'h2AA, 10'd7};

   lru_cache_hit_tracker dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_content_id (req_content_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_occupancy  (rsp_occupancy),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe both channels; results are checked before a same-edge request is noted
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid && !rsp_stall)
            board.check_result('{hit: rsp_hit, evicted: rsp_evicted,
                                 evicted_id: rsp_evicted_id, occupancy: rsp_occupancy});
         if (req_valid && !req_stall)
            board.note_request(req_content_id);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lru_cache_hit_tracker");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      if (!gaps_on) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Often identifiers already cached (hits at any depth), some from a small pool, some from the full range
   function automatic id_type pick_id(int pool);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (board.fill > 0) return board.order[$urandom_range(0, board.fill - 1)];
            return id_type'($urandom_range(0, pool - 1));
         end
         4, 5, 6: return id_type'($urandom_range(0, pool - 1));
         default: return id_type'($urandom_range(0, 1023));
      endcase
   endfunction

   // Offer one request and hold it until the transfer
   task automatic send_id(input id_type id);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_content_id <= id;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic offer_random(input int count, input int pool);
      repeat (count) send_id(pick_id(pool));
   endtask

   // Stop offering and wait for every owed result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.capacity = value;
   endtask

   // Result side: stall before the result or hold it once shown, one long hold
   initial begin : result_sink
      int wait_cycles;
      int taken;
      taken = 0;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         wait_cycles = (taken == LONG_HOLD_AT) ? LONG_HOLD : draw_gap();
         if (gaps_on && $urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (wait_cycles) @(posedge clock);
         end else if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Request side and configuration phases
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_content_id <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: fill, evict, hit at both ends
      foreach (directed_ids[i]) send_id(directed_ids[i]);
      settle();

      // capacity zero acts as one, already below the fill count
      write_capacity(10'd0);
      offer_random(150, 16);
      settle();

      // no idling on either side here
      gaps_on = 1'b0;
      write_capacity(10'd40);
      offer_random(300, 64);
      settle();

      // beyond the array: saturates, fills up and starts evicting
      gaps_on = 1'b1;
      write_capacity(10'd1023);
      offer_random(900, 1024);
      settle();

      write_capacity(10'd512);
      offer_random(200, 1024);
      settle();

      // far below the fill count: deep entries still hit
      write_capacity(10'd1);
      offer_random(200, 16);
      settle();

      write_capacity(10'd3);
      offer_random(100, 8);
      settle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding.size() == 0)
         $display("PASS lru_cache_hit_tracker");
      else
         $display("FAIL lru_cache_hit_tracker");
      $finish;
   end

endmodule

FILE: lru_cache_hit_tracker.f
hdl/lcht_pkg.sv
hdl/lcht_cell.sv
hdl/lcht_chain.sv
hdl/lru_cache_hit_tracker.sv
tb/lru_cache_hit_tracker_test.sv
